@@ src/tcw_pkg.sv @@
// shared types and constants of the text console writer
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // default screen geometry
  localparam int ROWS_DEF = 25;
  localparam int COLS_DEF = 80;

  // attribute of a written cell and the newline byte
  localparam logic [7:0] ATTR_LIT = 8'h07;
  localparam logic [7:0] NEWLINE  = 8'h0A;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_BLANK,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } request_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_char;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic [4:0] cursor_row_out;
    logic [6:0] cursor_col_out;
  } response_t;

endpackage

`default_nettype wire

@@ src/text_console_writer_top.sv @@
// text console writer: character-cell screen in one memory, cursor and command sequencer
`timescale 1ns / 1ps
`default_nettype none

// Character-cell screen of ROWS x COLS cells held in one single-port-write,
// registered-read memory of ROWS*COLS words (char plus one "attribute lit" bit).
// An item is taken at a rising edge with start high and busy low; its single
// result appears on response for exactly one cycle with done high and must be
// taken then, since the receiver cannot stall the block. Per item: a put
// shows its result in the next cycle and the next item may be started in that
// same cycle; a put that runs past the last row scrolls by moving a ring
// pointer over the memory rows and then blanks the new bottom row, keeping
// busy high while it writes that row, one cell write per cycle. A read
// presents its address in the accept cycle, the memory registers the data and
// the result is registered from it in ST_READ. A clear sweeps the whole
// memory, one cell per cycle, with busy high; its result shows right after
// acceptance. After reset the same clearing pass runs with busy high.
// Commands other than put, read and clear, and reads outside the screen, only
// report the cursor. A put also echoes its byte on response.

module text_console_writer_top #(
  parameter int ROWS = tcw_pkg::ROWS_DEF,
  parameter int COLS = tcw_pkg::COLS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  output logic                busy,
  input  tcw_pkg::request_t   request,
  output logic                done,
  output tcw_pkg::response_t  response
);

  localparam int CELLS  = ROWS * COLS;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);
  localparam int CELL_W = $clog2(CELLS);

  // memory word: [8] attribute lit, [7:0] char
  logic [8:0] mem [CELLS];
  logic [8:0] rd_data;

  logic              mem_we;
  logic [CELL_W-1:0] mem_waddr;
  logic [8:0]        mem_wdata;
  logic              mem_re;
  logic [CELL_W-1:0] mem_raddr;

  tcw_pkg::state_t   state, state_next;
  logic [ROW_W-1:0]  cursor_row, cursor_row_next;
  logic [COL_W-1:0]  cursor_col, cursor_col_next;
  logic [ROW_W-1:0]  top, top_next;         // memory row holding screen row 0
  logic [CELL_W-1:0] sweep, sweep_next;     // write address of clear and blank passes
  logic [COL_W-1:0]  blank_col, blank_col_next;
  logic              done_next;
  tcw_pkg::response_t response_next;

  logic accept;

  // memory address of a screen cell through the row ring
  function automatic logic [CELL_W-1:0] cell_addr(
    input logic [ROW_W-1:0] base,
    input logic [ROW_W-1:0] r,
    input logic [COL_W-1:0] c
  );
    logic [ROW_W:0] sum;
    sum = {1'b0, base} + {1'b0, r};
    if (sum >= (ROW_W + 1)'(ROWS)) begin
      sum = sum - (ROW_W + 1)'(ROWS);
    end
    return CELL_W'(sum[ROW_W-1:0]) * CELL_W'(COLS) + CELL_W'(c);
  endfunction

  assign busy   = (state != tcw_pkg::ST_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tcw_pkg::ST_CLEAR;
      cursor_row <= '0;
      cursor_col <= '0;
      top        <= '0;
      sweep      <= '0;
      blank_col  <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      cursor_row <= cursor_row_next;
      cursor_col <= cursor_col_next;
      top        <= top_next;
      sweep      <= sweep_next;
      blank_col  <= blank_col_next;
      done       <= done_next;
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk) begin
    response <= response_next;
  end

  always_comb begin
    logic row_inc;
    state_next      = state;
    cursor_row_next = cursor_row;
    cursor_col_next = cursor_col;
    top_next        = top;
    sweep_next      = sweep;
    blank_col_next  = blank_col;
    done_next       = 1'b0;
    response_next   = response;
    mem_we          = 1'b0;
    mem_waddr       = sweep;
    mem_wdata       = '0;
    mem_re          = 1'b0;
    mem_raddr       = cell_addr(top, ROW_W'(request.read_row), COL_W'(request.read_col));
    row_inc         = 1'b0;

    unique case (state)
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          response_next = '0;
          unique case (request.command)
            tcw_pkg::CMD_PUT: begin
              response_next.echo_valid = 1'b1;
              response_next.echo_char  = request.char_code;
              if (request.char_code == tcw_pkg::NEWLINE) begin
                cursor_col_next = '0;
                row_inc         = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(top, cursor_row, cursor_col);
                mem_wdata = {1'b1, request.char_code};
                if (cursor_col == COL_W'(COLS - 1)) begin
                  cursor_col_next = '0;
                  row_inc         = 1'b1;
                end else begin
                  cursor_col_next = cursor_col + 1'b1;
                end
              end
              if (row_inc) begin
                if (cursor_row == ROW_W'(ROWS - 1)) begin
                  // scroll: old top row becomes the new bottom row, blank it
                  top_next       = (top == ROW_W'(ROWS - 1)) ? '0 : top + 1'b1;
                  sweep_next     = CELL_W'(top) * CELL_W'(COLS);
                  blank_col_next = '0;
                  state_next     = tcw_pkg::ST_BLANK;
                end else begin
                  cursor_row_next = cursor_row + 1'b1;
                end
              end
              done_next = 1'b1;
            end
            tcw_pkg::CMD_READ: begin
              if (32'(request.read_row) < ROWS && 32'(request.read_col) < COLS) begin
                mem_re     = 1'b1;
                state_next = tcw_pkg::ST_READ;
              end else begin
                done_next = 1'b1;
              end
            end
            tcw_pkg::CMD_CLEAR: begin
              sweep_next = '0;
              state_next = tcw_pkg::ST_CLEAR;
              done_next  = 1'b1;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
          response_next.cursor_row_out = 5'(cursor_row_next);
          response_next.cursor_col_out = 7'(cursor_col_next);
        end
      end
      tcw_pkg::ST_READ: begin
        response_next.cell_char = rd_data[7:0];
        response_next.cell_attr = rd_data[8] ? tcw_pkg::ATTR_LIT : 8'h00;
        done_next  = 1'b1;
        state_next = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_BLANK: begin
        mem_we    = 1'b1;
        mem_wdata = {1'b1, 8'h00};
        sweep_next     = sweep + 1'b1;
        blank_col_next = blank_col + 1'b1;
        if (blank_col == COL_W'(COLS - 1)) begin
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_CLEAR: begin
        mem_we     = 1'b1;
        mem_wdata  = '0;
        sweep_next = sweep + 1'b1;
        if (sweep == CELL_W'(CELLS - 1)) begin
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  // cursor and ring pointer stay on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    32'(cursor_row) < ROWS && 32'(cursor_col) < COLS && 32'(top) < ROWS)
    else $error("cursor or top row out of range");

  // every item but a read answers in the next cycle
  a_fast_result: assert property (@(posedge clk) disable iff (rst)
    accept && request.command != tcw_pkg::CMD_READ |=> done)
    else $error("missing result after item");

  // the read state always raises the result strobe
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    state == tcw_pkg::ST_READ |-> done_next)
    else $error("read without result");

  // no read issued in a cycle that writes the memory
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("memory read and write in one cycle");

  // a result only follows an acceptance or the read state
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept) || $past(state) == tcw_pkg::ST_READ)
    else $error("result without source");

endmodule

`default_nettype wire
